@@ rtl/sgcp_pkg.sv @@
// Shared constants and types for the serial gain command parser.
`default_nettype none

package sgcp_pkg;

  // Characters that the parser recognises.
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;

  // Width of the digit accumulator and of the result fields.
  localparam int ACC_W   = 30;
  localparam int VALUE_W = 31;
  localparam int GAIN_W  = 33;

  // Codes for the gain that a command updates.
  typedef enum logic [1:0] {
    TGT_NONE  = 2'd0,
    TGT_ONE   = 2'd1,
    TGT_TWO   = 2'd2,
    TGT_THREE = 2'd3
  } target_t;

  // Result of one byte as seen by the output stage.
  typedef struct packed {
    logic               hit;
    target_t            target;
    logic [VALUE_W-1:0] value;
    logic [GAIN_W-1:0]  gain;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/sgcp_line_parser.sv @@
// Line state of the parser and the decode of one byte into a result.
`default_nettype none

module sgcp_line_parser #(
  parameter int LINE_LENGTH = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire logic [7:0]       rx_byte,
  output sgcp_pkg::result_t     result
);

  localparam int POS_W = (LINE_LENGTH > 1) ? $clog2(LINE_LENGTH) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(LINE_LENGTH - 1);

  logic [POS_W-1:0]             char_position;
  logic [POS_W-1:0]             char_position_next;
  logic [7:0]                   command_letter;
  logic [7:0]                   command_letter_next;
  logic                         minus_seen;
  logic                         minus_seen_next;
  logic                         number_closed;
  logic                         number_closed_next;
  logic                         digits_seen;
  logic                         digits_seen_next;
  logic [sgcp_pkg::ACC_W-1:0]   digit_accumulator;
  logic [sgcp_pkg::ACC_W-1:0]   digit_accumulator_next;

  logic                         is_semi;
  logic                         is_digit;
  logic                         is_minus;
  logic                         is_letter;
  logic [sgcp_pkg::ACC_W-1:0]   acc_times_ten;
  logic [sgcp_pkg::VALUE_W-1:0] magnitude;
  logic [sgcp_pkg::VALUE_W-1:0] value;
  logic [sgcp_pkg::GAIN_W-1:0]  value_ext;

  // Character classes.
  assign is_semi   = (rx_byte == sgcp_pkg::CH_SEMI);
  assign is_minus  = (rx_byte == sgcp_pkg::CH_MINUS);
  assign is_digit  = (rx_byte >= sgcp_pkg::CH_ZERO) && (rx_byte <= sgcp_pkg::CH_NINE);
  assign is_letter = (rx_byte >= sgcp_pkg::CH_A) && (rx_byte <= sgcp_pkg::CH_D);

  // Multiply by ten with two shifts and an add, then add the digit, kept to 30 bits.
  assign acc_times_ten = (digit_accumulator << 3) + (digit_accumulator << 1)
                         + sgcp_pkg::ACC_W'(rx_byte[3:0]);

  // Signed value of the number so far, and its sign extension to gain width.
  assign magnitude = {1'b0, digit_accumulator};
  assign value     = minus_seen ? (~magnitude + 1'b1) : magnitude;
  assign value_ext = {{(sgcp_pkg::GAIN_W - sgcp_pkg::VALUE_W){value[sgcp_pkg::VALUE_W-1]}},
                      value};

  // Next line state and the result that a ';' gives.
  always_comb begin
    char_position_next     = char_position;
    command_letter_next    = command_letter;
    minus_seen_next        = minus_seen;
    number_closed_next     = number_closed;
    digits_seen_next       = digits_seen;
    digit_accumulator_next = digit_accumulator;
    result.hit    = 1'b0;
    result.target = sgcp_pkg::TGT_NONE;
    result.value  = '0;
    result.gain   = '0;

    if (is_semi) begin
      result.hit = 1'b1;
      if (char_position != '0) begin
        result.value = value;
        case (command_letter)
          sgcp_pkg::CH_A: begin
            result.target = sgcp_pkg::TGT_ONE;
            result.gain   = value_ext;
          end
          sgcp_pkg::CH_B: begin
            result.target = sgcp_pkg::TGT_TWO;
            result.gain   = {value_ext[sgcp_pkg::GAIN_W-2:0], 1'b0};
          end
          sgcp_pkg::CH_C: begin
            result.target = sgcp_pkg::TGT_THREE;
            result.gain   = {value_ext[sgcp_pkg::GAIN_W-3:0], 2'b00};
          end
          default: begin
            result.target = sgcp_pkg::TGT_NONE;
          end
        endcase
      end
      char_position_next = '0;
    end else if (is_minus || is_digit || is_letter) begin
      if (char_position == '0) begin
        // The first accepted byte of a line is the command letter.
        command_letter_next    = rx_byte;
        minus_seen_next        = 1'b0;
        number_closed_next     = 1'b0;
        digits_seen_next       = 1'b0;
        digit_accumulator_next = '0;
      end else if (!number_closed) begin
        if (is_digit) begin
          digit_accumulator_next = acc_times_ten;
          digits_seen_next       = 1'b1;
        end else if (is_minus && !minus_seen && !digits_seen) begin
          minus_seen_next = 1'b1;
        end else begin
          number_closed_next = 1'b1;
        end
      end
      char_position_next = (char_position == LAST_POS) ? '0 : char_position + 1'b1;
    end
  end

  // Line state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_position     <= '0;
      command_letter    <= '0;
      minus_seen        <= 1'b0;
      number_closed     <= 1'b0;
      digits_seen       <= 1'b0;
      digit_accumulator <= '0;
    end else if (take) begin
      char_position     <= char_position_next;
      command_letter    <= command_letter_next;
      minus_seen        <= minus_seen_next;
      number_closed     <= number_closed_next;
      digits_seen       <= digits_seen_next;
      digit_accumulator <= digit_accumulator_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/serial_gain_command_parser_core.sv @@
// Top level of the serial gain command parser: input register, parser and result register.
`default_nettype none

// The block takes one received byte per cycle and gives one result item for every
// ';', from a line made of a command letter and a decimal number (atoi rules).
// An item is registered in the input register and moves into the parser when the result
// register can take it; the result that a ';' gives is registered in the result register.
// A new byte can be accepted in every cycle; the only hold-off is a full
// result register that is itself stalled. All work for a byte is one compare
// chain and a shift-and-add multiply by ten between those two registers.

module serial_gain_command_parser_core #(
  parameter int LINE_LENGTH = 10
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic [7:0]                          rx_byte,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic [1:0]                          target,
  output      logic signed [sgcp_pkg::VALUE_W-1:0] parsed_value,
  output      logic signed [sgcp_pkg::GAIN_W-1:0]  gain_value
);

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              advance;
  logic              take;
  sgcp_pkg::result_t result;

  // The input register moves on unless the result register is full and stalled.
  assign advance  = !(out_valid && out_stall);
  assign take     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= rx_byte;
    end
  end

  sgcp_line_parser #(
    .LINE_LENGTH(LINE_LENGTH)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .rx_byte(s1_byte),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && result.hit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && result.hit) begin
      target       <= result.target;
      parsed_value <= result.value;
      gain_value   <= result.gain;
    end
  end

  // A result with no target carries a zero gain.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (target == sgcp_pkg::TGT_NONE) |-> gain_value == '0)
    else $error("gain given without a target");

  // Gain one takes the parsed value unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (target == sgcp_pkg::TGT_ONE) |->
      gain_value == {{(sgcp_pkg::GAIN_W - sgcp_pkg::VALUE_W){parsed_value[sgcp_pkg::VALUE_W-1]}},
                     parsed_value})
    else $error("gain one differs from parsed value");

  // Gain three is a multiple of four.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (target == sgcp_pkg::TGT_THREE) |-> gain_value[1:0] == 2'b00)
    else $error("gain three not scaled by four");

  // Input is held off only behind a full, stalled result register.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the result register");

  // A ';' that moves forward always gives a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    take && (s1_byte == sgcp_pkg::CH_SEMI) |=> out_valid)
    else $error("terminator without a result item");

endmodule

`default_nettype wire
